>>> rtl/glbr_pkg.sv
// Shared types, constants and request codes for the grid line bitmap rasterizer.
// No dependencies; every other file but glbr_stream_if imports this package.
`default_nettype none

package glbr_pkg;

  // Default plane geometry, handed to the top level as parameter defaults.
  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;

  // Field widths.
  localparam int COORD_W   = 10;  // segment end coordinates
  localparam int QCOORD_W  = 16;  // signed query coordinates
  localparam int GEOM_W    = 11;  // grid_width and grid_height registers
  localparam int CFG_IDX_W = 2;

  // The pixel store keeps both planes side by side, one word of each per entry.
  localparam int WORD_BITS = 64;
  localparam int WORD_SH   = 6;

  localparam logic [GEOM_W-1:0] GRID_WIDTH_RST  = 11'd1024;
  localparam logic [GEOM_W-1:0] GRID_HEIGHT_RST = 11'd1024;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPLIT       = 2'd2;

  typedef enum logic [1:0] {
    REQ_CLEAR = 2'd0,
    REQ_DRAW  = 2'd1,
    REQ_QUERY = 2'd2,
    REQ_RSVD  = 2'd3
  } req_e;

  // Request item.
  typedef struct packed {
    logic [1:0]                 req_type;
    logic [COORD_W-1:0]         start_x;
    logic [COORD_W-1:0]         start_y;
    logic [COORD_W-1:0]         end_x;
    logic [COORD_W-1:0]         end_y;
    logic signed [QCOORD_W-1:0] query_x;
    logic signed [QCOORD_W-1:0] query_y;
    logic                       lat_line;
  } req_t;

  // Result item.
  typedef struct packed {
    logic on_grid;
    logic done_res;
  } rsp_t;

  // Segment command to the line walker.
  typedef struct packed {
    logic               start;
    logic [COORD_W-1:0] x1;
    logic [COORD_W-1:0] y1;
    logic [COORD_W-1:0] x2;
    logic [COORD_W-1:0] y2;
  } seg_t;

  // Pixel produced by the line walker.
  typedef struct packed {
    logic               vld;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } pix_t;

  // Pixel access to the store: set (wr) or read one bit.
  typedef struct packed {
    logic                       vld;
    logic                       wr;
    logic                       lon;
    logic signed [QCOORD_W-1:0] x;
    logic signed [QCOORD_W-1:0] y;
  } px_cmd_t;

  // Effective grid geometry.
  typedef struct packed {
    logic [GEOM_W-1:0] width;
    logic [GEOM_W-1:0] height;
  } geom_t;

  // Store status and read response.
  typedef struct packed {
    logic sweep;
    logic pipe_busy;
    logic rsp_vld;
    logic rsp_bit;
  } st_stat_t;

endpackage

`default_nettype wire

>>> rtl/glbr_stream_if.sv
// Valid/ready channel carrying one payload item per handshake.
// The payload type is set per instance; the block uses glbr_pkg::req_t and rsp_t.
`default_nettype none

interface glbr_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/glbr_walker.sv
// Line walker: turns a segment into one pixel per column with an error term.
// Depends on glbr_pkg; feeds pixels to the top level, which routes them to the store.
`default_nettype none

module glbr_walker
  import glbr_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  seg_t seg_i,
  output pix_t pix_o,
  output logic busy_o
);

  localparam int CNT_W = $clog2(COORD_W);

  typedef enum logic [3:0] {
    W_IDLE = 4'b0001,
    W_DIV  = 4'b0010,
    W_SIGN = 4'b0100,
    W_STEP = 4'b1000
  } wstate_e;

  wstate_e            state_q, state_d;
  logic               px_vld_q, px_vld_d;
  logic [COORD_W-1:0] x_q, x_d, y_q, y_d;
  logic               dir_q, dir_d;
  logic               dyneg_q, dyneg_d;
  logic [COORD_W-1:0] adx_q, adx_d;
  logic [COORD_W-1:0] quo_q, quo_d;
  logic [COORD_W-1:0] rem_q, rem_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [COORD_W:0]   qstep_q, qstep_d;  // two's complement row step per column
  logic [COORD_W:0]   r2_q, r2_d;        // twice the step remainder
  logic [COORD_W+1:0] err_q, err_d;
  logic [COORD_W-1:0] left_q, left_d;

  logic [COORD_W:0]   div_t;
  logic               div_ge;
  logic [COORD_W+1:0] err_sum;
  logic [COORD_W+1:0] adx2;
  logic               carry;

  always_comb begin
    state_d  = state_q;
    px_vld_d = 1'b0;
    x_d      = x_q;
    y_d      = y_q;
    dir_d    = dir_q;
    dyneg_d  = dyneg_q;
    adx_d    = adx_q;
    quo_d    = quo_q;
    rem_d    = rem_q;
    cnt_d    = cnt_q;
    qstep_d  = qstep_q;
    r2_d     = r2_q;
    err_d    = err_q;
    left_d   = left_q;

    div_t   = {rem_q, quo_q[COORD_W-1]};
    div_ge  = div_t >= {1'b0, adx_q};
    adx2    = {1'b0, adx_q, 1'b0};
    err_sum = err_q + {1'b0, r2_q};
    carry   = err_sum >= adx2;

    case (state_q)
      W_IDLE: begin
        if (seg_i.start) begin
          // The start pixel goes out at once.
          px_vld_d = 1'b1;
          x_d      = seg_i.x1;
          y_d      = seg_i.y1;
          dir_d    = seg_i.x2 < seg_i.x1;
          dyneg_d  = seg_i.y2 < seg_i.y1;
          adx_d    = dir_d ? seg_i.x1 - seg_i.x2 : seg_i.x2 - seg_i.x1;
          quo_d    = dyneg_d ? seg_i.y1 - seg_i.y2 : seg_i.y2 - seg_i.y1;
          rem_d    = '0;
          cnt_d    = CNT_W'(COORD_W - 1);
          err_d    = {2'b00, adx_d};
          if (adx_d != '0) begin
            state_d = W_DIV;
          end
        end
      end
      W_DIV: begin
        // Restoring division of |dy| by |dx|, one quotient bit per cycle.
        rem_d = div_ge ? COORD_W'(div_t - {1'b0, adx_q}) : div_t[COORD_W-1:0];
        quo_d = {quo_q[COORD_W-2:0], div_ge};
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = W_SIGN;
        end
      end
      W_SIGN: begin
        // Floor the step for a falling line so the remainder stays non-negative.
        if (dyneg_q) begin
          if (rem_q != '0) begin
            qstep_d = ~{1'b0, quo_q};
            r2_d    = {adx_q - rem_q, 1'b0};
          end else begin
            qstep_d = ~{1'b0, quo_q} + 1'b1;
            r2_d    = '0;
          end
        end else begin
          qstep_d = {1'b0, quo_q};
          r2_d    = {rem_q, 1'b0};
        end
        left_d  = adx_q;
        state_d = W_STEP;
      end
      W_STEP: begin
        px_vld_d = 1'b1;
        x_d      = dir_q ? x_q - 1'b1 : x_q + 1'b1;
        err_d    = carry ? err_sum - adx2 : err_sum;
        y_d      = COORD_W'({1'b0, y_q} + qstep_q + {{COORD_W{1'b0}}, carry});
        left_d   = left_q - 1'b1;
        if (left_q == COORD_W'(1)) begin
          state_d = W_IDLE;
        end
      end
      default: begin
        state_d = W_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= W_IDLE;
      px_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      px_vld_q <= px_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q     <= x_d;
    y_q     <= y_d;
    dir_q   <= dir_d;
    dyneg_q <= dyneg_d;
    adx_q   <= adx_d;
    quo_q   <= quo_d;
    rem_q   <= rem_d;
    cnt_q   <= cnt_d;
    qstep_q <= qstep_d;
    r2_q    <= r2_d;
    err_q   <= err_d;
    left_q  <= left_d;
  end

  assign pix_o.vld = px_vld_q;
  assign pix_o.x   = x_q;
  assign pix_o.y   = y_q;
  assign busy_o    = (state_q != W_IDLE) || px_vld_q;

endmodule

`default_nettype wire

>>> rtl/glbr_store.sv
// Pixel store: both bit planes in one synchronous memory, with address
// computation, read-modify-write, write forwarding and a clearing sweep. Uses glbr_pkg.
`default_nettype none

module glbr_store
  import glbr_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  px_cmd_t  cmd_i,
  input  geom_t    geom_i,
  input  logic     clr_start_i,
  output st_stat_t stat_o
);

  localparam int PLANE_BITS = MAX_WIDTH * MAX_HEIGHT;
  localparam int DEPTH      = (PLANE_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int AW         = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int POS_W      = AW + WORD_SH;
  localparam int ENTRY_W    = 2 * WORD_BITS;
  localparam int BIT_W      = WORD_SH + 1;
  localparam int PROD_W     = 2 * GEOM_W + 1;

  // Entry layout: longitude word in the upper half, latitude word in the lower.
  logic [ENTRY_W-1:0] mem [DEPTH];

  logic               in_range;
  logic [PROD_W-1:0]  pos_full;

  logic               s1_vld_q, s1_wr_q, s1_lon_q, s1_inr_q;
  logic [POS_W-1:0]   s1_pos_q;
  logic [AW-1:0]      rd_addr;
  logic [ENTRY_W-1:0] rd_q;

  logic               s2_vld_q, s2_wr_q, s2_inr_q;
  logic [BIT_W-1:0]   s2_bit_q;
  logic [AW-1:0]      s2_addr_q;

  logic               fwd_vld_q;
  logic [AW-1:0]      fwd_addr_q;
  logic [ENTRY_W-1:0] fwd_data_q;

  logic [ENTRY_W-1:0] merged;
  logic [ENTRY_W-1:0] set_data;
  logic               pix_we;

  logic               sweep_q;
  logic [AW-1:0]      cnt_q;

  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic [ENTRY_W-1:0] wr_data;

  // Range check and linear bit position y * width + x.
  assign in_range = !cmd_i.x[QCOORD_W-1] && !cmd_i.y[QCOORD_W-1]
                 && (cmd_i.x[QCOORD_W-2:0] < (QCOORD_W-1)'(geom_i.width))
                 && (cmd_i.y[QCOORD_W-2:0] < (QCOORD_W-1)'(geom_i.height));
  assign pos_full = PROD_W'(cmd_i.y[GEOM_W-1:0]) * PROD_W'(geom_i.width)
                  + PROD_W'(cmd_i.x[GEOM_W-1:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      fwd_vld_q <= 1'b0;
      sweep_q   <= 1'b1;
      cnt_q     <= '0;
    end else begin
      s1_vld_q  <= cmd_i.vld;
      s2_vld_q  <= s1_vld_q;
      fwd_vld_q <= pix_we;
      if (sweep_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == AW'(DEPTH - 1)) begin
          sweep_q <= 1'b0;
        end
      end else if (clr_start_i) begin
        sweep_q <= 1'b1;
        cnt_q   <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    s1_wr_q    <= cmd_i.wr;
    s1_lon_q   <= cmd_i.lon;
    s1_inr_q   <= in_range;
    s1_pos_q   <= POS_W'(pos_full);
    s2_wr_q    <= s1_wr_q;
    s2_inr_q   <= s1_inr_q;
    s2_bit_q   <= {s1_lon_q, s1_pos_q[WORD_SH-1:0]};
    s2_addr_q  <= rd_addr;
    fwd_addr_q <= s2_addr_q;
    fwd_data_q <= set_data;
  end

  assign rd_addr = s1_pos_q[POS_W-1:WORD_SH];

  // A write in the same cycle as the read of that entry is not seen by the
  // read, so the written entry is taken from the forwarding register.
  assign merged   = (fwd_vld_q && (fwd_addr_q == s2_addr_q)) ? fwd_data_q : rd_q;
  assign set_data = merged | (ENTRY_W'(1) << s2_bit_q);
  assign pix_we   = s2_vld_q && s2_wr_q && s2_inr_q;

  assign wr_en   = sweep_q || pix_we;
  assign wr_addr = sweep_q ? cnt_q : s2_addr_q;
  assign wr_data = sweep_q ? '0 : set_data;

  always_ff @(posedge clk_i) begin
    if (s1_vld_q) begin
      rd_q <= mem[rd_addr];
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  assign stat_o.sweep     = sweep_q;
  assign stat_o.pipe_busy = s1_vld_q || s2_vld_q;
  assign stat_o.rsp_vld   = s2_vld_q && !s2_wr_q;
  assign stat_o.rsp_bit   = s2_inr_q && merged[s2_bit_q];

endmodule

`default_nettype wire

>>> rtl/grid_line_bitmap_rasterizer.sv
// Grid line bitmap rasterizer: one or two bit planes, segment drawing, pixel query.
// Depends on glbr_pkg, glbr_stream_if, glbr_walker and glbr_store.
//
// Requests arrive on req_i (valid/ready) and each gives exactly one item on rsp_o.
// A clear zeroes both planes, a draw sets the pixels of a segment, a query
// returns one pixel bit in on_grid (0 outside the grid); done_res is always 1.
// Registers are written through cfg_we_i / cfg_idx_i / cfg_data_i while idle.
// Requests are handled one at a time; req_i.ready is high only in idle, so the
// next request can be taken in the same cycle as a result is presented.
// A query passes the store address register, the memory read, result capture and the
// output register; a reserved request passes only the done state and output register.
// A draw answers once its last pixel has been written; for a non-vertical segment
// a restoring divide and a sign step first set up the row step per column, then
// the walker issues one pixel per cycle into a read-modify-write pipeline that
// forwards back-to-back writes to one entry.
// A clear sweeps all MAX_WIDTH*MAX_HEIGHT/64 entries of the store, one entry per cycle
// (16384 entries with default parameters), and answers after the sweep ends.
// After reset the same sweep runs once before the first request is accepted;
// configuration writes are taken during it. The result sits in an output register,
// so a stalled receiver only holds back the following request once it has finished.
`default_nettype none

module grid_line_bitmap_rasterizer
  import glbr_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [GEOM_W-1:0]    cfg_data_i,
  glbr_stream_if.sink          req_i,
  glbr_stream_if.source        rsp_o
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_DRAW  = 5'b00010,
    S_CLEAR = 5'b00100,
    S_QUERY = 5'b01000,
    S_DONE  = 5'b10000
  } state_e;

  // Clamp values wide enough to hold the largest parameter.
  localparam logic [GEOM_W+2:0] MAXW_C = (GEOM_W+3)'(MAX_WIDTH);
  localparam logic [GEOM_W+2:0] MAXH_C = (GEOM_W+3)'(MAX_HEIGHT);

  state_e            state_q, state_d;
  logic [GEOM_W-1:0] gw_q, gh_q;
  logic              split_q;
  logic              lon_q, lon_d;
  logic              bit_q, bit_d;
  logic              out_vld_q, out_vld_d;
  logic              out_bit_q, out_bit_d;

  req_t     req;
  req_e     kind;
  logic     accept;
  logic     req_lon;
  geom_t    geom;
  seg_t     seg;
  pix_t     pix;
  logic     wk_busy;
  px_cmd_t  cmd;
  logic     clr_start;
  st_stat_t st;

  assign req     = req_i.data;
  assign kind    = req_e'(req.req_type);
  assign accept  = req_i.valid && req_i.ready;
  // Single mode routes everything to the latitude plane.
  assign req_lon = split_q && !req.lat_line;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gw_q    <= GRID_WIDTH_RST;
      gh_q    <= GRID_HEIGHT_RST;
      split_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_GRID_WIDTH:  gw_q    <= cfg_data_i;
        CFG_GRID_HEIGHT: gh_q    <= cfg_data_i;
        CFG_SPLIT:       split_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Effective geometry never exceeds the plane size.
  assign geom.width  = ({3'b000, gw_q} > MAXW_C) ? GEOM_W'(MAXW_C) : gw_q;
  assign geom.height = ({3'b000, gh_q} > MAXH_C) ? GEOM_W'(MAXH_C) : gh_q;

  // A draw starts the walker directly from the accepted item.
  assign seg.start = accept && (kind == REQ_DRAW);
  assign seg.x1    = req.start_x;
  assign seg.y1    = req.start_y;
  assign seg.x2    = req.end_x;
  assign seg.y2    = req.end_y;

  glbr_walker u_walker (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .seg_i  (seg),
    .pix_o  (pix),
    .busy_o (wk_busy)
  );

  // Walker pixels and query reads share the store port; they never overlap.
  always_comb begin
    if (pix.vld) begin
      cmd.vld = 1'b1;
      cmd.wr  = 1'b1;
      cmd.lon = lon_q;
      cmd.x   = {{(QCOORD_W-COORD_W){1'b0}}, pix.x};
      cmd.y   = {{(QCOORD_W-COORD_W){1'b0}}, pix.y};
    end else begin
      cmd.vld = accept && (kind == REQ_QUERY);
      cmd.wr  = 1'b0;
      cmd.lon = req_lon;
      cmd.x   = req.query_x;
      cmd.y   = req.query_y;
    end
  end

  // The store pipeline is always empty in idle, so a clear can start at once.
  assign clr_start = accept && (kind == REQ_CLEAR);

  glbr_store #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_store (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .geom_i      (geom),
    .clr_start_i (clr_start),
    .stat_o      (st)
  );

  // Request sequencing and output register.
  always_comb begin
    state_d   = state_q;
    lon_d     = lon_q;
    bit_d     = bit_q;
    out_vld_d = out_vld_q && !rsp_o.ready;
    out_bit_d = out_bit_q;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          lon_d = req_lon;
          bit_d = 1'b0;
          case (kind)
            REQ_CLEAR: state_d = S_CLEAR;
            REQ_DRAW:  state_d = S_DRAW;
            REQ_QUERY: state_d = S_QUERY;
            default:   state_d = S_DONE;
          endcase
        end
      end
      S_DRAW: begin
        // Done once the last pixel write has left the store pipeline.
        if (!wk_busy && !st.pipe_busy) begin
          state_d = S_DONE;
        end
      end
      S_CLEAR: begin
        if (!st.sweep) begin
          state_d = S_DONE;
        end
      end
      S_QUERY: begin
        if (st.rsp_vld) begin
          bit_d   = st.rsp_bit;
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_vld_q || rsp_o.ready) begin
          out_vld_d = 1'b1;
          out_bit_d = bit_q;
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lon_q     <= lon_d;
    bit_q     <= bit_d;
    out_bit_q <= out_bit_d;
  end

  assign req_i.ready        = (state_q == S_IDLE) && !st.sweep;
  assign rsp_o.valid        = out_vld_q;
  assign rsp_o.data.on_grid  = out_bit_q;
  assign rsp_o.data.done_res = 1'b1;

`ifndef ASSERT_OFF
  a_walker_in_draw : assert property (@(posedge clk_i) disable iff (!rst_ni)
    wk_busy |-> (state_q == S_DRAW))
    else $error("line walker active outside a draw");

  a_rsp_in_query : assert property (@(posedge clk_i) disable iff (!rst_ni)
    st.rsp_vld |-> (state_q == S_QUERY))
    else $error("store read response outside a query");

  a_clear_on_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_start |-> (!st.pipe_busy && !wk_busy))
    else $error("clear started with pixel accesses in flight");

  a_out_from_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> ($past(state_q) == S_DONE))
    else $error("result presented without a finished request");
`endif

endmodule

`default_nettype wire

>>> bench/glbr_raster_monitor.sv
`timescale 1ns / 100ps
// Watches the request, result and register ports of the grid line bitmap rasterizer,
// keeps its own copy of both bit planes and checks every result item in order.
// Depends on glbr_pkg only.

module glbr_raster_monitor
  import glbr_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [GEOM_W-1:0]    cfg_data_i,
  input  logic                 req_valid_i,
  input  logic                 req_ready_i,
  input  req_t                 req_data_i,
  input  logic                 rsp_valid_i,
  input  logic                 rsp_ready_i,
  input  rsp_t                 rsp_data_i,
  output int                   mismatch_cnt_o,
  output int                   pending_o
);

  logic [GEOM_W-1:0] width_q  = GRID_WIDTH_RST;
  logic [GEOM_W-1:0] height_q = GRID_HEIGHT_RST;
  logic              split_q  = 1'b0;

  // Only set pixels are stored, keyed by their bit position in the plane.
  bit   lat_bits [longint];
  bit   lon_bits [longint];
  rsp_t pending_answers [$];
  rsp_t want;
  int   fault_cnt = 0;

  function automatic longint eff_width();
    return (width_q > MAX_WIDTH) ? longint'(MAX_WIDTH) : longint'(width_q);
  endfunction

  function automatic longint eff_height();
    return (height_q > MAX_HEIGHT) ? longint'(MAX_HEIGHT) : longint'(height_q);
  endfunction

  // Bit position of a pixel, or -1 when it lies outside the grid in use.
  function automatic longint pixel_pos(longint x, longint y);
    longint w;
    longint h;
    w = eff_width();
    h = eff_height();
    if (x < 0 || y < 0 || x >= w || y >= h) return -1;
    return y * w + x;
  endfunction

  function automatic void set_pixel(longint x, longint y, bit lon);
    longint pos;
    pos = pixel_pos(x, y);
    if (pos < 0) return;
    if (lon) lon_bits[pos] = 1'b1;
    else lat_bits[pos] = 1'b1;
  endfunction

  function automatic bit pixel_bit(longint x, longint y, bit lon);
    longint pos;
    pos = pixel_pos(x, y);
    if (pos < 0) return 1'b0;
    return lon ? lon_bits.exists(pos) : lat_bits.exists(pos);
  endfunction

  // Row of each column is start_y + dy*n/|dx| rounded half up, done in integers.
  function automatic void draw_line(req_t r, bit lon);
    longint x1;
    longint y1;
    longint dx;
    longint dy;
    longint adx;
    longint num;
    longint row;
    x1  = longint'(r.start_x);
    y1  = longint'(r.start_y);
    dx  = longint'(r.end_x) - x1;
    dy  = longint'(r.end_y) - y1;
    adx = (dx < 0) ? -dx : dx;
    set_pixel(x1, y1, lon);
    for (longint n = 1; n <= adx; n++) begin
      num = 2 * dy * n + adx;
      row = (num >= 0) ? num / (2 * adx) : -((-num + 2 * adx - 1) / (2 * adx));
      set_pixel((dx < 0) ? x1 - n : x1 + n, y1 + row, lon);
    end
  endfunction

  function automatic rsp_t rasterize_request(req_t r);
    rsp_t res;
    bit   lon;
    res.on_grid  = 1'b0;
    res.done_res = 1'b1;
    lon = split_q && !r.lat_line;
    case (r.req_type)
      REQ_CLEAR: begin
        lat_bits.delete();
        lon_bits.delete();
      end
      REQ_DRAW:  draw_line(r, lon);
      REQ_QUERY: res.on_grid = pixel_bit(longint'($signed(r.query_x)),
                                         longint'($signed(r.query_y)), lon);
      default: ;
    endcase
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  = GRID_WIDTH_RST;
      height_q = GRID_HEIGHT_RST;
      split_q  = 1'b0;
      lat_bits.delete();
      lon_bits.delete();
      pending_answers.delete();
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_GRID_WIDTH:  width_q  = cfg_data_i;
          CFG_GRID_HEIGHT: height_q = cfg_data_i;
          CFG_SPLIT:       split_q  = cfg_data_i[0];
          default: ;
        endcase
      end
      // The result is checked before this edge's request is added, so a result
      // can never be matched with a request accepted in the same cycle.
      if (rsp_valid_i && rsp_ready_i) begin
        if (pending_answers.size() == 0) begin
          $error("result item with no request outstanding: on_grid %0b, done_res %0b",
                 rsp_data_i.on_grid, rsp_data_i.done_res);
          fault_cnt++;
        end else begin
          want = pending_answers.pop_front();
          if (rsp_data_i.on_grid !== want.on_grid) begin
            $error("on_grid mismatch: expected %0b, actual %0b",
                   want.on_grid, rsp_data_i.on_grid);
            fault_cnt++;
          end
          if (rsp_data_i.done_res !== want.done_res) begin
            $error("done_res mismatch: expected %0b, actual %0b",
                   want.done_res, rsp_data_i.done_res);
            fault_cnt++;
          end
        end
      end
      if (req_valid_i && req_ready_i) pending_answers.push_back(rasterize_request(req_data_i));
      pending_o <= pending_answers.size();
    end
    mismatch_cnt_o <= fault_cnt;
  end

endmodule

>>> bench/testbench.sv
`timescale 1ns / 100ps
// Top level of the grid line bitmap rasterizer testbench: clock, reset, register
// writes, request items and the verdict. Depends on glbr_pkg, glbr_stream_if,
// glbr_raster_monitor and the block itself.

module testbench;
  import glbr_pkg::*;

  localparam int IDLE_PCT     = 30;      // share of cycles each side idles when idling is on
  localparam int STALL_LIMIT  = 100000;  // cycles with no handshake before giving up
  localparam int DRAIN_CYCLES = 64;
  localparam int COORD_MAX    = (1 << COORD_W) - 1;
  localparam int RECENT_DEPTH = 8;

  // Index 3 holds no register; writing it must leave the block unchanged.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [GEOM_W-1:0]    cfg_data_i;

  glbr_stream_if #(.payload_t(req_t)) req_if ();
  glbr_stream_if #(.payload_t(rsp_t)) rsp_if ();

  int   mismatch_cnt;
  int   pending_cnt;
  int   quiet_cycles = 0;
  bit   calm;             // while set, neither side idles
  int   grid_w;           // effective geometry, steers the random coordinates
  int   grid_h;
  req_t recent_segs [$];  // last few segments drawn, aimed at by queries

  grid_line_bitmap_rasterizer uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .req_i      (req_if),
    .rsp_o      (rsp_if)
  );

  glbr_raster_monitor raster_mon (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .req_valid_i    (req_if.valid),
    .req_ready_i    (req_if.ready),
    .req_data_i     (req_if.data),
    .rsp_valid_i    (rsp_if.valid),
    .rsp_ready_i    (rsp_if.ready),
    .rsp_data_i     (rsp_if.data),
    .mismatch_cnt_o (mismatch_cnt),
    .pending_o      (pending_cnt)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // The result side is ready with a chance of about seven in ten, or always
  // during the calm stretch.
  always @(posedge clk_i) begin
    if (calm) begin
      rsp_if.ready <= 1'b1;
    end else begin
      rsp_if.ready <= ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Watchdog: a clear or the sweep after reset is the longest legal silence,
  // and the limit leaves ample margin over it.
  always @(posedge clk_i) begin
    if (!rst_ni || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("grid_line_bitmap_rasterizer test failed");
      $finish;
    end
  end

  function automatic logic [COORD_W-1:0] coord_clamp(int v);
    if (v < 0) return '0;
    if (v > COORD_MAX) return COORD_W'(COORD_MAX);
    return COORD_W'(v);
  endfunction

  // A coordinate on or just past the border of the grid, or a 16-bit extreme.
  function automatic int rim_value(int limit);
    case ($urandom_range(5))
      0: return -32768;
      1: return -1;
      2: return 0;
      3: return limit - 1;
      4: return limit;
      default: return 32767;
    endcase
  endfunction

  function automatic req_t mk_req(req_e kind, int sx, int sy, int ex, int ey,
                                  int qx, int qy, bit lat);
    req_t r;
    r.req_type = kind;
    r.start_x  = COORD_W'(sx);
    r.start_y  = COORD_W'(sy);
    r.end_x    = COORD_W'(ex);
    r.end_y    = COORD_W'(ey);
    r.query_x  = QCOORD_W'(qx);
    r.query_y  = QCOORD_W'(qy);
    r.lat_line = lat;
    return r;
  endfunction

  // Random request item. Unused fields keep random bits. Draws mostly stay
  // near the grid in use and are short; one in ten spans the whole 10-bit
  // range. Half of the queries aim at or next to a recently drawn segment so
  // that set pixels are actually read back.
  function automatic req_t random_item();
    req_t        r;
    req_t        seg;
    logic [95:0] noise;
    int          pick;
    int          xr;
    int          yr;
    int          span;
    int          yspan;
    int          sx;
    int          sy;
    int          dx;
    int          dy;
    int          adx;
    int          n;
    int          qx;
    int          qy;
    noise = {$urandom, $urandom, $urandom};
    r     = noise[$bits(req_t)-1:0];
    xr    = (grid_w + 2 > COORD_MAX) ? COORD_MAX : grid_w + 2;
    yr    = (grid_h + 2 > COORD_MAX) ? COORD_MAX : grid_h + 2;
    pick  = $urandom_range(99);
    if (pick < 2) begin
      r.req_type = REQ_CLEAR;
    end else if (pick < 8) begin
      r.req_type = REQ_RSVD;
    end else if (pick < 50) begin
      r.req_type = REQ_DRAW;
      if ($urandom_range(9) != 0) begin
        span      = $urandom_range(40);
        yspan     = $urandom_range(60);
        sx        = $urandom_range(xr);
        sy        = $urandom_range(yr);
        r.start_x = COORD_W'(sx);
        r.start_y = COORD_W'(sy);
        r.end_x   = coord_clamp(sx + int'($urandom_range(2 * span)) - span);
        r.end_y   = coord_clamp(sy + int'($urandom_range(2 * yspan)) - yspan);
      end
      recent_segs.push_back(r);
      if (recent_segs.size() > RECENT_DEPTH) void'(recent_segs.pop_front());
    end else begin
      r.req_type = REQ_QUERY;
      pick = $urandom_range(99);
      if (pick < 50 && recent_segs.size() != 0) begin
        seg = recent_segs[$urandom_range(recent_segs.size() - 1)];
        dx  = int'(seg.end_x) - int'(seg.start_x);
        dy  = int'(seg.end_y) - int'(seg.start_y);
        adx = (dx < 0) ? -dx : dx;
        n   = $urandom_range(adx);
        qx  = int'(seg.start_x) + ((dx < 0) ? -n : n);
        qy  = int'(seg.start_y) + ((adx == 0) ? 0 : dy * n / adx)
              + int'($urandom_range(2)) - 1;
        r.lat_line = ($urandom_range(3) == 0) ? !seg.lat_line : seg.lat_line;
      end else if (pick < 75) begin
        qx = int'($urandom_range(grid_w + 3)) - 2;
        qy = int'($urandom_range(grid_h + 3)) - 2;
      end else if (pick < 88) begin
        qx = int'($signed(r.query_x));
        qy = int'($signed(r.query_y));
      end else begin
        qx = rim_value(grid_w);
        qy = rim_value(grid_h);
      end
      r.query_x = QCOORD_W'(qx);
      r.query_y = QCOORD_W'(qy);
    end
    return r;
  endfunction

  // One register write; the block takes it at the edge where cfg_we_i is high.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [GEOM_W-1:0] value);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  task automatic set_geometry(input int w, input int h, input bit split);
    write_reg(CFG_GRID_WIDTH, GEOM_W'(w));
    write_reg(CFG_GRID_HEIGHT, GEOM_W'(h));
    write_reg(CFG_SPLIT, GEOM_W'(split));
    grid_w = (w > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : w;
    grid_h = (h > MAX_HEIGHT_DEF) ? MAX_HEIGHT_DEF : h;
  endtask

  // Offers one item and returns at the edge where it is accepted. Valid is
  // left high so that a following item can go out back to back; a gap lowers
  // it in the step where the gap starts.
  task automatic send_item(input req_t item);
    if (!calm) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        req_if.valid <= 1'b0;
        @(posedge clk_i);
      end
    end
    req_if.valid <= 1'b1;
    req_if.data  <= item;
    do @(posedge clk_i); while (!req_if.ready);
  endtask

  // Ends a batch: no more items offered, then wait until every result is in.
  // The block handles one request at a time, so it is idle afterwards.
  task automatic drain();
    req_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending_cnt != 0);
  endtask

  task automatic run_random(input int count);
    repeat (count) send_item(random_item());
    drain();
  endtask

  initial begin
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = CFG_GRID_WIDTH;
    cfg_data_i   = '0;
    req_if.valid = 1'b0;
    req_if.data  = '0;
    rsp_if.ready = 1'b0;
    calm         = 1'b0;
    grid_w       = MAX_WIDTH_DEF;
    grid_h       = MAX_HEIGHT_DEF;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // The store sweeps itself clear after reset; register writes are taken
    // meanwhile and the first request waits for the sweep to finish.
    write_reg(CFG_UNUSED, '1);
    set_geometry(1024, 1024, 1'b0);

    // Directed items on the full grid with one shared plane. A longitude
    // draw must land in the shared plane and be seen by a latitude query.
    send_item(mk_req(REQ_QUERY, 0, 0, 0, 0, 0, 0, 1'b1));
    send_item(mk_req(REQ_RSVD, 1023, 1023, 1023, 1023, -1, -1, 1'b1));
    // Row 1/2 at column 2 rounds up to row 1.
    send_item(mk_req(REQ_DRAW, 0, 0, 4, 1, 0, 0, 1'b0));
    send_item(mk_req(REQ_QUERY, 0, 0, 0, 0, 2, 1, 1'b1));
    send_item(mk_req(REQ_QUERY, 0, 0, 0, 0, 2, 0, 1'b0));
    // Full-length diagonals, one walked right to left.
    send_item(mk_req(REQ_DRAW, 1023, 1023, 0, 0, 0, 0, 1'b1));
    send_item(mk_req(REQ_DRAW, 0, 1023, 1023, 0, 0, 0, 1'b0));
    send_item(mk_req(REQ_QUERY, 0, 0, 0, 0, 1023, 0, 1'b1));
    // A vertical segment sets its start pixel and nothing else.
    send_item(mk_req(REQ_DRAW, 5, 100, 5, 900, 0, 0, 1'b1));
    send_item(mk_req(REQ_QUERY, 0, 0, 0, 0, 5, 100, 1'b1));
    send_item(mk_req(REQ_QUERY, 0, 0, 0, 0, 5, 101, 1'b1));
    // Steep segment drawn right to left.
    send_item(mk_req(REQ_DRAW, 100, 900, 40, 10, 0, 0, 1'b0));
    // Falling by half a row at column 12 rounds up, back to row 10.
    send_item(mk_req(REQ_DRAW, 10, 10, 14, 9, 0, 0, 1'b1));
    send_item(mk_req(REQ_QUERY, 0, 0, 0, 0, 12, 10, 1'b1));
    send_item(mk_req(REQ_QUERY, 0, 0, 0, 0, 12, 9, 1'b1));
    // Queries at the corners of the grid, just outside it and at 16-bit extremes.
    send_item(mk_req(REQ_QUERY, 0, 0, 0, 0, -32768, -32768, 1'b1));
    send_item(mk_req(REQ_QUERY, 0, 0, 0, 0, 32767, 32767, 1'b0));
    send_item(mk_req(REQ_QUERY, 0, 0, 0, 0, 1023, 1023, 1'b1));
    send_item(mk_req(REQ_QUERY, 0, 0, 0, 0, 1024, 0, 1'b1));
    send_item(mk_req(REQ_QUERY, 0, 0, 0, 0, 0, 1024, 1'b1));
    send_item(mk_req(REQ_QUERY, 0, 0, 0, 0, -1, 5, 1'b1));
    // A clear wipes what was drawn; a single-point segment sets one pixel.
    send_item(mk_req(REQ_CLEAR, 0, 0, 0, 0, 0, 0, 1'b0));
    send_item(mk_req(REQ_QUERY, 0, 0, 0, 0, 1023, 1023, 1'b1));
    send_item(mk_req(REQ_DRAW, 0, 0, 0, 0, 0, 0, 1'b0));
    send_item(mk_req(REQ_QUERY, 0, 0, 0, 0, 0, 0, 1'b1));
    drain();

    // Split planes, starting with a stretch in which neither side idles.
    calm <= 1'b1;
    set_geometry(1024, 1024, 1'b1);
    run_random(40);
    calm <= 1'b0;
    run_random(50);

    // A small grid keeps many writes and queries beyond the border.
    set_geometry(37, 23, 1'b1);
    run_random(70);

    // Oversized registers clamp to the full plane; the switch to one plane
    // keeps both planes as they are, so earlier latitude pixels stay visible.
    set_geometry(2047, 2047, 1'b0);
    run_random(60);

    // Empty grids: every write is dropped and every query answers 0.
    set_geometry(0, 9, 1'b1);
    run_random(30);
    set_geometry(9, 0, 1'b1);
    run_random(30);

    // Smallest grid, then single-row and narrow full-height grids.
    set_geometry(1, 1, 1'b0);
    run_random(30);
    set_geometry(1024, 1, 1'b1);
    run_random(40);
    set_geometry(3, 1024, 1'b0);
    run_random(40);

    // Give a stray late result the chance to show up before the verdict.
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("grid_line_bitmap_rasterizer test passed");
    end else begin
      $display("grid_line_bitmap_rasterizer test failed");
    end
    $finish;
  end

endmodule
